/* sv/ptd_pkg.sv */
package ptd_pkg;

   // table geometry
   localparam int SLOTS     = 16;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ID_BITS   = 8;

   // field widths
   localparam int CMD_W    = 3;
   localparam int ID_W     = 8;
   localparam int TAG_W    = 8;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [ID_W-1:0] ID_MASK =
      (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << ID_BITS) - 1);

   // commands
   localparam logic [CMD_W-1:0] CMD_SERVICE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_QUEUE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CHANGE   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

   // register select (byte address bit 2)
   localparam logic CSR_SEL_IDLE_EN = 1'b0;
   localparam logic CSR_SEL_ROLL    = 1'b1;

   localparam logic [TIME_W-1:0] ROLL_RESET = 32'h4000_0000;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] due;
      logic [TIME_W-1:0] period;
   } slot_type;

   typedef struct packed {
      logic                 en_key;
      logic                 en_due;
      logic                 en_period;
      logic [SLOT_BITS-1:0] addr;
      slot_type             data;
   } wr_type;

endpackage

/* sv/periodic_task_dispatcher.sv */
// Periodic task dispatcher: a table of SLOTS task slots (id, tag, due time,
// period) plus a millisecond time counter.
// Request channel (req_*): one command item per handshake; accepted at a
// rising edge with req_valid high and req_stall low. Commands: service,
// schedule, queue now, remove, change period, clock tick.
// Result channel (rsp_*): exactly one result item per request, held in an
// output register until taken (rsp_valid high, rsp_stall low).
// CSR port: idle_enable at byte 0x0, roll_period at 0x4; writes land on the
// access cycle, pready is tied high.
// Sequence: after acceptance the sequencer sweeps all SLOTS entries through a
// single 32-bit comparator (one slot per cycle), then runs the adder step and
// the table update step, which also loads the result register. req_stall
// stays high until that update is done, so no new item is taken before the
// last one is through.
// A result waiting in the output register does not block acceptance; only the
// final update step waits for the register to drain if rsp_stall is held.
// Reset: all slots empty, time zero, idle_enable 0, roll_period 0x40000000.
module periodic_task_dispatcher (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ptd_pkg::CMD_W-1:0]    req_cmd,
   input  logic [ptd_pkg::ID_W-1:0]     req_task_id,
   input  logic [ptd_pkg::TAG_W-1:0]    req_tag,
   input  logic [ptd_pkg::TIME_W-1:0]   req_delay,
   input  logic [ptd_pkg::TIME_W-1:0]   req_period,
   input  logic                         req_update_next,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ptd_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_dispatched,
   output logic                         rsp_idle,
   output logic [ptd_pkg::ID_W-1:0]     rsp_run_id,
   output logic [ptd_pkg::TAG_W-1:0]    rsp_run_tag,
   output logic                         rsp_present,

   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ptd_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ptd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ptd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import ptd_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_CALC  = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

   // control
   logic [1:0]           state_ff, state_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [TIME_W-1:0]    time_now_ff, time_now_in;
   logic                 roll_ff, roll_in;
   logic                 idle_en_ff, idle_en_in;
   logic [TIME_W-1:0]    roll_period_ff, roll_period_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // latched item
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [TIME_W-1:0]    delay_ff, delay_in;
   logic [TIME_W-1:0]    period_ff, period_in;
   logic                 upd_ff, upd_in;

   // sweep results
   logic                 best_any_ff, best_any_in;
   logic [SLOT_BITS-1:0] best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]    best_due_ff, best_due_in;
   logic                 any_ff, any_in;        // surviving id match seen
   logic                 multi_ff, multi_in;    // more than one such match
   logic [SLOT_BITS-1:0] first_ff, first_in;    // lowest surviving id match
   logic                 free_any_ff, free_any_in;
   logic [SLOT_BITS-1:0] free_ff, free_in;
   logic                 found_ff, found_in;    // remove freed something
   logic [TIME_W:0]      sum_ff, sum_in;
   logic                 due_ok_ff, due_ok_in;

   // result register
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 disp_ff, disp_in;
   logic                 idle_ff, idle_in;
   logic [ID_W-1:0]      run_id_ff, run_id_in;
   logic [TAG_W-1:0]     run_tag_ff, run_tag_in;
   logic                 present_ff, present_in;

   // datapath
   wr_type               wr;
   slot_type             rd;
   logic [SLOT_BITS-1:0] rd_addr;
   logic [SLOT_BITS-1:0] tgt;
   logic [TIME_W-1:0]    cmp_a, cmp_b;
   logic                 cmp_lt;
   logic [TIME_W:0]      add_a, add_b;
   logic [TIME_W-1:0]    tick_time;
   logic [TIME_W-1:0]    sat_sum;
   logic [TIME_W:0]      chg_diff;
   logic [TIME_W:0]      chg_t;
   logic [TIME_W-1:0]    chg_due;
   logic                 scan_v, id_hit, rm_hit;
   logic                 out_free;
   logic                 csr_wr;

   ptd_slot_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd      (rd)
   );

   // slot the update step works on
   always_comb begin
      case (cmd_ff)
         CMD_SERVICE:             tgt = best_idx_ff;
         CMD_SCHEDULE, CMD_QUEUE: tgt = free_ff;
         default:                 tgt = first_ff;
      endcase
   end

   assign rd_addr = (state_ff == ST_SCAN) ? idx_ff : tgt;

   // the shared comparator: min search during service sweeps, due > now during
   // roll sweeps, due <= now check in the calc step
   always_comb begin
      cmp_a = rd.due;
      cmp_b = best_due_ff;
      if (state_ff == ST_SCAN && cmd_ff == CMD_TICK) begin
         cmp_a = time_now_ff;
         cmp_b = rd.due;
      end else if (state_ff == ST_CALC) begin
         cmp_a = time_now_ff;
         cmp_b = best_due_ff;
      end
   end
   assign cmp_lt = (cmp_a < cmp_b);

   // shared adder operands for the calc step
   always_comb begin
      case (cmd_ff)
         CMD_SCHEDULE: begin
            add_a = {1'b0, time_now_ff};
            add_b = {1'b0, delay_ff};
         end
         CMD_CHANGE: begin
            add_a = {1'b0, rd.due};
            add_b = {1'b0, period_ff};
         end
         default: begin
            add_a = {1'b0, rd.due};
            add_b = {1'b0, rd.period};
         end
      endcase
   end

   assign tick_time = (time_now_ff == {TIME_W{1'b1}}) ? time_now_ff
                                                       : time_now_ff + TIME_W'(1);
   assign sat_sum   = sum_ff[TIME_W] ? {TIME_W{1'b1}} : sum_ff[TIME_W-1:0];
   assign chg_diff  = sum_ff - {1'b0, rd.period};
   assign chg_t     = (sum_ff > {1'b0, rd.period}) ? chg_diff : '0;
   assign chg_due   = chg_t[TIME_W] ? {TIME_W{1'b1}} : chg_t[TIME_W-1:0];

   assign scan_v = valid_ff[idx_ff];
   assign id_hit = scan_v && (rd.id == id_ff);
   assign rm_hit = (cmd_ff == CMD_REMOVE) && id_hit &&
                   ((tag_ff == '0) || ((rd.tag == tag_ff) && !found_ff));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      valid_in       = valid_ff;
      time_now_in    = time_now_ff;
      roll_in        = roll_ff;
      idle_en_in     = idle_en_ff;
      roll_period_in = roll_period_ff;
      rsp_valid_in   = rsp_valid_ff;
      cmd_in         = cmd_ff;
      id_in          = id_ff;
      tag_in         = tag_ff;
      delay_in       = delay_ff;
      period_in      = period_ff;
      upd_in         = upd_ff;
      best_any_in    = best_any_ff;
      best_idx_in    = best_idx_ff;
      best_due_in    = best_due_ff;
      any_in         = any_ff;
      multi_in       = multi_ff;
      first_in       = first_ff;
      free_any_in    = free_any_ff;
      free_in        = free_ff;
      found_in       = found_ff;
      sum_in         = sum_ff;
      due_ok_in      = due_ok_ff;
      status_in      = status_ff;
      disp_in        = disp_ff;
      idle_in        = idle_ff;
      run_id_in      = run_id_ff;
      run_tag_in     = run_tag_ff;
      present_in     = present_ff;

      wr             = '0;
      wr.addr        = tgt;
      wr.data.id     = id_ff;
      wr.data.tag    = tag_ff;
      wr.data.due    = sat_sum;
      wr.data.period = period_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr) begin
         if (csr_paddr[2] == CSR_SEL_ROLL) begin
            roll_period_in = csr_pwdata[TIME_W-1:0];
         end else begin
            idle_en_in = csr_pwdata[0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_cmd;
               id_in       = req_task_id & ID_MASK;
               tag_in      = req_tag;
               delay_in    = req_delay;
               period_in   = req_period;
               upd_in      = req_update_next;
               idx_in      = '0;
               best_any_in = 1'b0;
               any_in      = 1'b0;
               multi_in    = 1'b0;
               free_any_in = 1'b0;
               found_in    = 1'b0;
               roll_in     = 1'b0;
               // tick: bump time now so the sweep can roll against it
               if (req_cmd == CMD_TICK) begin
                  time_now_in = tick_time;
                  roll_in     = !(tick_time < roll_period_ff);
               end
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (rm_hit) begin
               valid_in[idx_ff] = 1'b0;
               found_in         = 1'b1;
            end
            if (id_hit && !rm_hit) begin
               if (!any_ff) begin
                  any_in   = 1'b1;
                  first_in = idx_ff;
               end else begin
                  multi_in = 1'b1;
               end
            end
            if (!scan_v && !free_any_ff) begin
               free_any_in = 1'b1;
               free_in     = idx_ff;
            end
            // strict less-than keeps the lowest slot on ties
            if (cmd_ff == CMD_SERVICE && scan_v && (!best_any_ff || cmp_lt)) begin
               best_any_in = 1'b1;
               best_idx_in = idx_ff;
               best_due_in = rd.due;
            end
            // rollover: due above now drops by now, the rest go to zero
            if (cmd_ff == CMD_TICK && roll_ff && scan_v) begin
               wr.en_due   = 1'b1;
               wr.addr     = idx_ff;
               wr.data.due = cmp_lt ? (rd.due - time_now_ff) : '0;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_CALC;
            end else begin
               idx_in = idx_ff + SLOT_BITS'(1);
            end
         end

         ST_CALC: begin
            sum_in    = add_a + add_b;
            due_ok_in = !cmp_lt;
            state_in  = ST_WRITE;
         end

         ST_WRITE: begin
            if (out_free) begin
               status_in  = STATUS_DONE;
               disp_in    = 1'b0;
               idle_in    = 1'b0;
               run_id_in  = '0;
               run_tag_in = '0;
               present_in = any_ff;
               case (cmd_ff)
                  CMD_SERVICE: begin
                     if (best_any_ff && due_ok_ff) begin
                        disp_in    = 1'b1;
                        run_id_in  = rd.id;
                        run_tag_in = rd.tag;
                        if (rd.period != '0) begin
                           wr.en_due = 1'b1;
                        end else begin
                           // one-shot: slot freed, id may vanish with it
                           valid_in[best_idx_ff] = 1'b0;
                           present_in = multi_ff || (any_ff && (first_ff != best_idx_ff));
                        end
                     end else begin
                        status_in = STATUS_NONE;
                        idle_in   = idle_en_ff;
                     end
                  end
                  CMD_SCHEDULE, CMD_QUEUE: begin
                     if (free_any_ff) begin
                        valid_in[free_ff] = 1'b1;
                        wr.en_key         = 1'b1;
                        wr.en_due         = 1'b1;
                        wr.en_period      = 1'b1;
                        if (cmd_ff == CMD_QUEUE) begin
                           wr.data.due    = time_now_ff;
                           wr.data.period = '0;
                        end
                        present_in = 1'b1;
                     end else begin
                        status_in = STATUS_FULL;
                     end
                  end
                  CMD_REMOVE: begin
                     status_in = found_ff ? STATUS_DONE : STATUS_NONE;
                  end
                  CMD_CHANGE: begin
                     if (any_ff) begin
                        wr.en_due      = upd_ff;
                        wr.data.due    = chg_due;
                        wr.en_period   = 1'b1;
                     end else begin
                        status_in = STATUS_NONE;
                     end
                  end
                  CMD_TICK: begin
                     if (roll_ff) begin
                        time_now_in = '0;
                     end
                  end
                  default: begin
                     status_in = STATUS_NONE;
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         time_now_ff    <= '0;
         roll_ff        <= 1'b0;
         idle_en_ff     <= 1'b0;
         roll_period_ff <= ROLL_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         time_now_ff    <= time_now_in;
         roll_ff        <= roll_in;
         idle_en_ff     <= idle_en_in;
         roll_period_ff <= roll_period_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      tag_ff      <= tag_in;
      delay_ff    <= delay_in;
      period_ff   <= period_in;
      upd_ff      <= upd_in;
      best_any_ff <= best_any_in;
      best_idx_ff <= best_idx_in;
      best_due_ff <= best_due_in;
      any_ff      <= any_in;
      multi_ff    <= multi_in;
      first_ff    <= first_in;
      free_any_ff <= free_any_in;
      free_ff     <= free_in;
      found_ff    <= found_in;
      sum_ff      <= sum_in;
      due_ok_ff   <= due_ok_in;
      status_ff   <= status_in;
      disp_ff     <= disp_in;
      idle_ff     <= idle_in;
      run_id_ff   <= run_id_in;
      run_tag_ff  <= run_tag_in;
      present_ff  <= present_in;
   end

   // busy for the whole sweep and update
   assign req_stall = (state_ff != ST_IDLE);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_dispatched = disp_ff;
   assign rsp_idle       = idle_ff;
   assign rsp_run_id     = run_id_ff;
   assign rsp_run_tag    = run_tag_ff;
   assign rsp_present    = present_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_SEL_ROLL) ? roll_period_ff
                                                      : {{(CSR_DW-1){1'b0}}, idle_en_ff};

endmodule

/* sv/ptd_slot_table.sv */
module ptd_slot_table (
   input  logic                          clock,
   input  ptd_pkg::wr_type               wr,
   input  logic [ptd_pkg::SLOT_BITS-1:0] rd_addr,
   output ptd_pkg::slot_type             rd
);
   import ptd_pkg::*;

   logic [ID_W-1:0]   id_ff     [SLOTS];
   logic [TAG_W-1:0]  tag_ff    [SLOTS];
   logic [TIME_W-1:0] due_ff    [SLOTS];
   logic [TIME_W-1:0] period_ff [SLOTS];

   always_ff @(posedge clock) begin
      if (wr.en_key) begin
         id_ff[wr.addr]  <= wr.data.id;
         tag_ff[wr.addr] <= wr.data.tag;
      end
      if (wr.en_due) begin
         due_ff[wr.addr] <= wr.data.due;
      end
      if (wr.en_period) begin
         period_ff[wr.addr] <= wr.data.period;
      end
   end

   // single read port, one address per cycle
   assign rd.id     = id_ff[rd_addr];
   assign rd.tag    = tag_ff[rd_addr];
   assign rd.due    = due_ff[rd_addr];
   assign rd.period = period_ff[rd_addr];

endmodule

/* sv/ptd_monitor.sv */
module ptd_monitor (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ptd_pkg::STATUS_W-1:0] rsp_status,
   input logic                         rsp_dispatched,
   input logic                         rsp_idle,
   input logic [ptd_pkg::ID_W-1:0]     rsp_run_id,
   input logic [ptd_pkg::TAG_W-1:0]    rsp_run_tag
);
   import ptd_pkg::*;

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_FULL ||
                     rsp_status == STATUS_NONE))
      else $error("result status out of range");

   a_dispatch_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dispatched) |-> (rsp_status == STATUS_DONE && !rsp_idle))
      else $error("dispatched item carries bad status or idle");

   a_run_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_dispatched) |-> (rsp_run_id == '0 && rsp_run_tag == '0))
      else $error("run id or tag set without dispatch");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken before sweep finished");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_run_id) && $stable(rsp_run_tag)))
      else $error("stalled result changed");

endmodule

bind periodic_task_dispatcher ptd_monitor u_ptd_monitor (.*);

/* verif/tb.sv */
module tb;
   import ptd_pkg::*;

   // Unused command codes; the block must answer them with "no match".
   localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

   localparam int SETTLE         = SLOTS + 8;   // cycles to let the sweep finish
   localparam int HOLDOFF_CYCLES = 400;         // long result-side stall
   localparam int CYCLE_LIMIT    = 400000;

   // One command item as it crosses the request channel.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ID_W-1:0]   task_id;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;
      logic              update_next;
   } command_type;

   // One result item.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                dispatched;
      logic                idle;
      logic [ID_W-1:0]     run_id;
      logic [TAG_W-1:0]    run_tag;
      logic                present;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd         = '0;
   logic [ID_W-1:0]     req_task_id     = '0;
   logic [TAG_W-1:0]    req_tag         = '0;
   logic [TIME_W-1:0]   req_delay       = '0;
   logic [TIME_W-1:0]   req_period      = '0;
   logic                req_update_next = 1'b0;

   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_dispatched;
   logic                rsp_idle;
   logic [ID_W-1:0]     rsp_run_id;
   logic [TAG_W-1:0]    rsp_run_tag;
   logic                rsp_present;

   logic                csr_psel        = 1'b0;
   logic                csr_penable     = 1'b0;
   logic                csr_pwrite      = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr       = '0;
   logic [CSR_DW-1:0]   csr_pwdata      = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   periodic_task_dispatcher u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_task_id     (req_task_id),
      .req_tag         (req_tag),
      .req_delay       (req_delay),
      .req_period      (req_period),
      .req_update_next (req_update_next),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_dispatched  (rsp_dispatched),
      .rsp_idle        (rsp_idle),
      .rsp_run_id      (rsp_run_id),
      .rsp_run_tag     (rsp_run_tag),
      .rsp_present     (rsp_present),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // ---------------------------------------------------------------------
   // Shadow of the task table, time counter and registers.
   // ---------------------------------------------------------------------
   bit                tbl_valid  [SLOTS] = '{default: 1'b0};
   logic [ID_W-1:0]   tbl_id     [SLOTS];
   logic [TAG_W-1:0]  tbl_tag    [SLOTS];
   logic [TIME_W-1:0] tbl_due    [SLOTS];
   logic [TIME_W-1:0] tbl_period [SLOTS];
   logic [TIME_W-1:0] now_ms  = '0;
   logic              idle_en = 1'b0;
   logic [TIME_W-1:0] roll_at = ROLL_RESET;

   outcome_type expected_outcomes [$];   // oldest first

   int  cycle_count   = 0;
   int  mismatches    = 0;
   int  items_sent    = 0;
   int  results_seen  = 0;
   int  dispatch_hits = 0;
   int  full_hits     = 0;
   int  roll_count    = 0;
   bit  steady        = 1'b0;         // no idling on either side while set
   int  holdoff_seq   = 0;            // bump to start a long result stall
   int  holdoff_seen  = 0;
   int  holdoff_left  = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog: a hung handshake ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_outcomes.size());
      $display("periodic_task_dispatcher test failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[cycle %0d] mismatch: %s", cycle_count, what);
   endtask

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
   endfunction

   // Lowest free slot takes the task; no free slot means table full.
   function automatic logic [STATUS_W-1:0] store_task(input logic [ID_W-1:0] id,
                                                      input logic [TAG_W-1:0] tag,
                                                      input logic [TIME_W-1:0] due,
                                                      input logic [TIME_W-1:0] per);
      for (int i = 0; i < SLOTS; i++) begin
         if (!tbl_valid[i]) begin
            tbl_valid[i]  = 1'b1;
            tbl_id[i]     = id;
            tbl_tag[i]    = tag;
            tbl_due[i]    = due;
            tbl_period[i] = per;
            return STATUS_DONE;
         end
      end
      return STATUS_FULL;
   endfunction

   // Applies one command to the shadow table and returns its result item.
   function automatic outcome_type apply_command(input command_type c);
      outcome_type     o;
      logic [ID_W-1:0] id;
      logic [TIME_W:0] wide;
      int              best;
      bit              stop;
      o    = '0;
      id   = c.task_id & ID_MASK;
      best = -1;
      stop = 1'b0;
      case (c.cmd)
         CMD_SERVICE: begin
            // earliest due time wins, lowest slot on a tie
            for (int i = 0; i < SLOTS; i++)
               if (tbl_valid[i] && (best < 0 || tbl_due[i] < tbl_due[best]))
                  best = i;
            if (best >= 0 && tbl_due[best] <= now_ms) begin
               o.dispatched = 1'b1;
               o.run_id     = tbl_id[best];
               o.run_tag    = tbl_tag[best];
               if (tbl_period[best] != '0)
                  tbl_due[best] = sat_sum(tbl_due[best], tbl_period[best]);
               else
                  tbl_valid[best] = 1'b0;
            end else begin
               o.status = STATUS_NONE;
               o.idle   = idle_en;
            end
         end
         CMD_SCHEDULE: o.status = store_task(id, c.tag, sat_sum(now_ms, c.delay), c.period);
         CMD_QUEUE:    o.status = store_task(id, c.tag, now_ms, '0);
         CMD_REMOVE: begin
            // tag zero frees every slot of the id, otherwise only the first match
            o.status = STATUS_NONE;
            for (int i = 0; i < SLOTS; i++) begin
               if (!stop && tbl_valid[i] && tbl_id[i] == id &&
                   (c.tag == '0 || tbl_tag[i] == c.tag)) begin
                  tbl_valid[i] = 1'b0;
                  o.status     = STATUS_DONE;
                  stop         = (c.tag != '0);
               end
            end
         end
         CMD_CHANGE: begin
            for (int i = SLOTS - 1; i >= 0; i--)
               if (tbl_valid[i] && tbl_id[i] == id)
                  best = i;
            if (best < 0) begin
               o.status = STATUS_NONE;
            end else begin
               if (c.update_next) begin
                  // due + new - old, clamped to the 32-bit range
                  wide = {1'b0, tbl_due[best]} + {1'b0, c.period};
                  wide = (wide > {1'b0, tbl_period[best]}) ?
                         wide - {1'b0, tbl_period[best]} : '0;
                  tbl_due[best] = wide[TIME_W] ? '1 : wide[TIME_W-1:0];
               end
               tbl_period[best] = c.period;
            end
         end
         CMD_TICK: begin
            if (now_ms != '1)
               now_ms = now_ms + 1'b1;
            if (now_ms >= roll_at) begin
               // future due times shift down, past ones collapse to zero
               for (int i = 0; i < SLOTS; i++)
                  if (tbl_valid[i])
                     tbl_due[i] = (tbl_due[i] > now_ms) ? tbl_due[i] - now_ms : '0;
               now_ms = '0;
               roll_count++;
            end
         end
         default: o.status = STATUS_NONE;
      endcase
      // presence is reported on every item, after the update
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i] && tbl_id[i] == id)
            o.present = 1'b1;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offers one item (after optional idle cycles) and holds it until taken.
   // Valid is only dropped by the idle loop or by wait_results, never here,
   // so back-to-back items keep it high.
   task automatic send_item(input command_type c);
      outcome_type o;
      while (!steady && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= c.cmd;
      req_task_id     <= c.task_id;
      req_tag         <= c.tag;
      req_delay       <= c.delay;
      req_period      <= c.period;
      req_update_next <= c.update_next;
      do @(posedge clock); while (req_stall);
      o = apply_command(c);
      expected_outcomes.push_back(o);
      items_sent++;
      if (o.dispatched)
         dispatch_hits++;
      if (o.status == STATUS_FULL)
         full_hits++;
   endtask

   task automatic issue(input logic [CMD_W-1:0]  cmd,
                        input logic [ID_W-1:0]   id     = '0,
                        input logic [TAG_W-1:0]  tag    = '0,
                        input logic [TIME_W-1:0] delay  = '0,
                        input logic [TIME_W-1:0] period = '0,
                        input logic              upd    = 1'b0);
      command_type c;
      c = '{cmd: cmd, task_id: id, tag: tag, delay: delay, period: period,
            update_next: upd};
      send_item(c);
   endtask

   // Mostly small ids, tags and times so commands hit live slots; now and
   // then a full-range value so every field bit toggles.
   function automatic command_type random_command();
      command_type c;
      int          pick;
      pick = $urandom_range(99);
      if      (pick < 28) c.cmd = CMD_TICK;
      else if (pick < 50) c.cmd = CMD_SERVICE;
      else if (pick < 66) c.cmd = CMD_SCHEDULE;
      else if (pick < 75) c.cmd = CMD_QUEUE;
      else if (pick < 86) c.cmd = CMD_REMOVE;
      else if (pick < 97) c.cmd = CMD_CHANGE;
      else if (pick < 99) c.cmd = CMD_RSVD_6;
      else                c.cmd = CMD_RSVD_7;
      c.task_id = ID_W'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                 : $urandom_range(7));
      case ($urandom_range(7))
         0, 1:    c.tag = '0;
         2:       c.tag = TAG_W'($urandom_range(255));
         default: c.tag = TAG_W'($urandom_range(1, 3));
      endcase
      case ($urandom_range(9))
         0:       c.delay = $urandom;
         1:       c.delay = '0;
         default: c.delay = $urandom_range(20);
      endcase
      case ($urandom_range(9))
         0:       c.period = $urandom;
         1, 2:    c.period = '0;
         default: c.period = $urandom_range(1, 15);
      endcase
      c.update_next = 1'($urandom_range(1));
      return c;
   endfunction

   // Drops valid and waits until every expected result has been taken.
   task automatic wait_results(input int settle);
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Register write (setup + access), then a read back of the same register.
   task automatic write_reg(input logic sel, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] seen;
      logic [CSR_DW-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (sel == CSR_SEL_IDLE_EN) begin
         idle_en = value[0];
         want    = {{(CSR_DW-1){1'b0}}, value[0]};
      end else begin
         roll_at = value[TIME_W-1:0];
         want    = value;
      end
      if (seen !== want)
         report_mismatch($sformatf("register read back %h, wrote %h", seen, want));
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (holdoff_seq != holdoff_seen) begin
         holdoff_seen = holdoff_seq;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left = holdoff_left - 1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 29);
      end
   end

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                   results_seen, name, got, want));
   endtask

   // Every taken result is matched against the oldest prediction.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("result item with nothing outstanding");
         end else begin
            want = expected_outcomes.pop_front();
            check_field("status",     32'(rsp_status),     32'(want.status));
            check_field("dispatched", 32'(rsp_dispatched), 32'(want.dispatched));
            check_field("idle",       32'(rsp_idle),       32'(want.idle));
            check_field("run_id",     32'(rsp_run_id),     32'(want.run_id));
            check_field("run_tag",    32'(rsp_run_tag),    32'(want.run_tag));
            check_field("present",    32'(rsp_present),    32'(want.present));
         end
         results_seen++;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Every command, tie-break, one-shot vs periodic, saturation, all
   // remove and change-period flavors, unused codes.
   task automatic test_directed_ops();
      issue(CMD_SERVICE);                 // empty table, idle still off from reset
      wait_results(SETTLE);
      write_reg(CSR_SEL_IDLE_EN, 32'd1);
      write_reg(CSR_SEL_ROLL, '1);
      issue(CMD_SERVICE);                 // empty table, idle reported
      issue(CMD_RSVD_6, 8'hFF, 8'hFF, '1, '1, 1'b1);
      issue(CMD_RSVD_7);
      issue(CMD_TICK);
      issue(CMD_SCHEDULE, 8'hFF, 8'hFF, '1, '1, 1'b1);   // due saturates
      issue(CMD_QUEUE, 8'h01, 8'h00);
      issue(CMD_QUEUE, 8'h02, 8'h02);     // same due time: lower slot first
      issue(CMD_SERVICE);
      issue(CMD_SERVICE);
      issue(CMD_SERVICE);                 // only the far-future task left
      issue(CMD_SCHEDULE, 8'h10, 8'h05, 32'd0, 32'd3);
      issue(CMD_SCHEDULE, 8'h10, 8'h06, 32'd0, 32'd7);
      issue(CMD_CHANGE, 8'h10, 8'h00, 32'd0, 32'd1, 1'b1);    // shift clamps at zero
      issue(CMD_CHANGE, 8'h10, 8'h00, 32'd0, 32'hFFFF_FFFF, 1'b0);
      issue(CMD_CHANGE, 8'h77, 8'h00, 32'd0, 32'd9, 1'b1);    // no such id
      issue(CMD_SERVICE);                 // periodic: due += huge period
      issue(CMD_SERVICE);
      issue(CMD_REMOVE, 8'h10, 8'h06);
      issue(CMD_REMOVE, 8'h10, 8'h00);
      issue(CMD_REMOVE, 8'h10, 8'h00);    // nothing left to match
      issue(CMD_QUEUE, 8'h20, 8'h01);
      issue(CMD_QUEUE, 8'h20, 8'h01);
      issue(CMD_REMOVE, 8'h20, 8'h01);    // first match only, id stays present
      issue(CMD_REMOVE, 8'hFF, 8'hFF);
      issue(CMD_REMOVE, 8'h20, 8'h00);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < SLOTS; i++)
         issue(CMD_QUEUE, 8'h3C, TAG_W'(i + 1));
      issue(CMD_SCHEDULE, 8'h3D, 8'h01, 32'd5, 32'd5);
      issue(CMD_QUEUE, 8'h3D, 8'h02);
      issue(CMD_REMOVE, 8'h3C, 8'h00);    // frees the whole table
   endtask

   task automatic test_rollover();
      wait_results(SETTLE);
      write_reg(CSR_SEL_ROLL, 32'd4);
      issue(CMD_QUEUE, 8'h01, 8'h01);
      issue(CMD_SCHEDULE, 8'h02, 8'h02, 32'd9);
      repeat (4) issue(CMD_TICK);         // crosses the roll point once
      issue(CMD_SERVICE);
      issue(CMD_SERVICE);
      wait_results(SETTLE);
      write_reg(CSR_SEL_ROLL, 32'd1);     // period of one: roll on every tick
      repeat (2) issue(CMD_TICK);
      issue(CMD_SERVICE);
      issue(CMD_REMOVE, 8'h02, 8'h00);
   endtask

   task automatic test_random_mix(input int count, input logic idle_setting,
                                  input logic [CSR_DW-1:0] roll_setting);
      wait_results(SETTLE);
      write_reg(CSR_SEL_IDLE_EN, {{(CSR_DW-1){1'b0}}, idle_setting});
      write_reg(CSR_SEL_ROLL, roll_setting);
      repeat (count) send_item(random_command());
   endtask

   task automatic test_steady_stream(input int count);
      wait_results(1);
      steady = 1'b1;
      repeat (count) send_item(random_command());
      wait_results(1);
      steady = 1'b0;
   endtask

   // Result side blocks for a long stretch while items keep coming, so the
   // block backs up and stalls its request channel.
   task automatic test_output_holdoff(input int count);
      holdoff_seq++;
      repeat (count) send_item(random_command());
   endtask

   task automatic test_one_at_a_time(input int count);
      repeat (count) begin
         send_item(random_command());
         wait_results(0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_full_table();
      test_rollover();
      test_random_mix(100, 1'b0, 32'd24);
      test_steady_stream(80);
      test_output_holdoff(40);
      test_random_mix(60, 1'b1, 32'd1);
      test_one_at_a_time(30);
      test_random_mix(40, 1'b0, $urandom_range(5, 200));

      wait_results(SETTLE);
      $display("%0d items, %0d results: %0d dispatches, %0d table-full, %0d rollovers",
               items_sent, results_seen, dispatch_hits, full_hits, roll_count);
      $display("register settings swept: idle on/off, roll period 1, 4, 24, max");
      if (mismatches == 0)
         $display("periodic_task_dispatcher test passed");
      else
         $display("periodic_task_dispatcher test failed");
      $finish;
   end

endmodule

/* periodic_task_dispatcher.f */
sv/ptd_pkg.sv
sv/ptd_slot_table.sv
sv/periodic_task_dispatcher.sv
sv/ptd_monitor.sv
verif/tb.sv
